/* hdl/pls_pkg.sv */
// Shared types and constants for the positional list store.
package pls_pkg;

  localparam int LIST_DEPTH  = 64;
  localparam int ENTRY_WIDTH = 32;

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int DATA_W  = 32;

  localparam int IDX_W   = $clog2(LIST_DEPTH);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GROUP_SZ = 8;
  localparam int NGROUP   = (LIST_DEPTH + GROUP_SZ - 1) / GROUP_SZ;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_READ       = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_OPEN,
    CM_CLOSE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    idx_t       at;
    entry_t     value;
    logic       rd_en;
    idx_t       rd_idx;
  } cell_cmd_t;

endpackage

/* hdl/pls_if.sv */
// Handshake channels for operation words and result words.
interface pls_op_if;
  import pls_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface pls_res_if;
  import pls_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;
  logic [DATA_W-1:0]  read_data;

  modport source (output valid, status, entry_count, read_data, input ready);
  modport sink   (input valid, status, entry_count, read_data, output ready);
endinterface

/* hdl/positional_list_store_top.sv */
// Top level of the positional list store: decode, count and result stages.
//
// Ordered list of up to LIST_DEPTH entries held in a row of cells. Each word
// on op_i is one operation (push back/front, pop back/front, insert before a
// position, erase at a position, read at a position); each gives exactly one
// word on res_o with a status, the entry count after the operation and, for
// a good read, the entry read (zero otherwise).
//
// Every cell updates in the same cycle as its neighbours, so an insert or an
// erase shifts the whole list in the cycle the word is accepted. A read goes
// through a two-level OR tree: groups of eight cells are registered in the
// first stage, the groups are merged into the result register in the second.
// The first stage loads at the accepting edge; the result register loads from
// it once the register is empty or its word is being taken, and res_o then
// shows the result word as valid. One word per cycle is sustained while
// res_o is taken.
//
// Reset clears the count and both stage valids; cell contents are left as
// they are and are never read before being written. When the receiver stalls
// the result register holds, the first stage fills, then op_i ready drops
// until the result word is taken.
module positional_list_store_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  pls_op_if.sink        op_i,
  pls_res_if.source     res_o
);
  import pls_pkg::*;

  cnt_t      count_q, count_d;
  status_e   dec_status;
  cell_cmd_t cmd;
  entry_t    grp [NGROUP];
  entry_t    rd_merge;

  logic      s1_valid_q;
  status_e   s1_status_q;
  cnt_t      s1_count_q;

  logic      out_valid_q;
  status_e   out_status_q;
  cnt_t      out_count_q;
  logic [DATA_W-1:0] out_data_q;

  logic      accept, out_adv;
  logic      full, empty;
  logic [CMP_W-1:0] pos_x, cnt_x;
  op_e       op;

  // Handshake: move stage one on when the result register frees up.
  assign out_adv     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign op_i.ready  = !s1_valid_q || out_adv;
  assign accept      = op_i.valid && op_i.ready;

  assign op    = op_e'(op_i.operation);
  assign full  = (count_q == CNT_W'(LIST_DEPTH));
  assign empty = (count_q == '0);
  assign pos_x = CMP_W'(op_i.position);
  assign cnt_x = CMP_W'(count_q);

  // Decode: status, next count and the command for the cell row.
  always_comb begin
    dec_status = ST_OK;
    count_d    = count_q;
    cmd.mode   = CM_HOLD;
    cmd.at     = '0;
    cmd.value  = ENTRY_WIDTH'(op_i.value);
    cmd.rd_en  = 1'b0;
    cmd.rd_idx = IDX_W'(op_i.position);
    unique case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          cmd.mode = CM_OPEN;
          cmd.at   = (op == OP_PUSH_BACK) ? IDX_W'(count_q) : '0;
          count_d  = count_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          cmd.mode = CM_CLOSE;
          count_d  = count_q - 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          cmd.mode = CM_OPEN;
          cmd.at   = IDX_W'(op_i.position);
          count_d  = count_q + 1'b1;
        end
      end
      OP_ERASE: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          cmd.mode = CM_CLOSE;
          cmd.at   = IDX_W'(op_i.position);
          count_d  = count_q - 1'b1;
        end
      end
      OP_READ: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = ST_RANGE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      default: dec_status = ST_OK;
    endcase
    // Drop everything unless the word is actually taken this cycle.
    if (!accept) begin
      cmd.mode  = CM_HOLD;
      cmd.rd_en = 1'b0;
    end
  end

  pls_cell_row u_row (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .adv_i (accept),
    .grp_o (grp)
  );

  // Merge the registered groups; unselected cells contribute zero.
  always_comb begin
    rd_merge = '0;
    for (int g = 0; g < NGROUP; g++) begin
      rd_merge = rd_merge | grp[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= dec_status;
      s1_count_q  <= count_d;
    end
    if (out_adv) begin
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
      out_data_q   <= DATA_W'(rd_merge);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.entry_count = COUNT_W'(out_count_q);
  assign res_o.read_data   = out_data_q;

  // Count never runs past the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  // A refused operation leaves the count alone.
  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (dec_status != ST_OK) |=> $stable(count_q))
    else $error("refused operation changed the count");

  // A good push raises the count by one.
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (dec_status == ST_OK) && ((op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT))
    |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not advance the count");

  // A refused result carries zero data.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_OK) |-> out_data_q == '0)
    else $error("refused result carries read data");

endmodule

/* hdl/pls_cell.sv */
// One list cell: holds an entry, takes from a neighbour on open or close.
module pls_cell (
  input  logic               clk_i,
  input  pls_pkg::idx_t      idx_i,
  input  pls_pkg::cell_cmd_t cmd_i,
  input  pls_pkg::entry_t    lower_i,
  input  pls_pkg::entry_t    upper_i,
  output pls_pkg::entry_t    data_o,
  output pls_pkg::entry_t    sel_o
);
  import pls_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.mode)
      CM_OPEN: begin
        if (idx_i == cmd_i.at) begin
          entry_d = cmd_i.value;
        end else if (idx_i > cmd_i.at) begin
          entry_d = lower_i;
        end
      end
      CM_CLOSE: begin
        if (idx_i >= cmd_i.at) begin
          entry_d = upper_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;
  assign sel_o  = (cmd_i.rd_en && (cmd_i.rd_idx == idx_i)) ? entry_q : '0;

endmodule

/* hdl/pls_cell_row.sv */
// Row of list cells with a registered OR tree for the read port.
module pls_cell_row (
  input  logic               clk_i,
  input  pls_pkg::cell_cmd_t cmd_i,
  input  logic               adv_i,
  output pls_pkg::entry_t    grp_o [pls_pkg::NGROUP]
);
  import pls_pkg::*;

  entry_t data  [LIST_DEPTH];
  entry_t sel   [LIST_DEPTH];
  entry_t grp_d [NGROUP];
  entry_t grp_q [NGROUP];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign upper = data[i];
    end else begin : g_mid_hi
      assign upper = data[i+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd_i),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (data[i]),
      .sel_o   (sel[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (g * GROUP_SZ + k < LIST_DEPTH) begin
          grp_d[g] = grp_d[g] | sel[g * GROUP_SZ + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

/* sim/pls_list_board_pkg.sv */
// Scoreboard class that mirrors the list contents and queues predicted result words.
`timescale 1ns / 100ps

package pls_list_board_pkg;
  import pls_pkg::*;

  class list_result_board;
    typedef struct {
      status_e            status;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  data;
    } list_result_t;

    entry_t       entries [LIST_DEPTH];
    int           held;
    list_result_t pending_q [$];
    int           errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int held_count();
      return held;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void open_at(int at);
      for (int i = held; i > at; i--) entries[i] = entries[i-1];
    endfunction

    function void close_at(int at);
      for (int i = at; i + 1 < held; i++) entries[i] = entries[i+1];
    endfunction

    // Apply one accepted operation word and queue the result it should give.
    function void note_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos_b,
                          logic [VALUE_W-1:0] value);
      list_result_t r;
      int           pos;
      entry_t       v;
      pos      = int'(pos_b);
      v        = value[ENTRY_WIDTH-1:0];
      r.status = ST_OK;
      r.data   = '0;
      case (op)
        OP_PUSH_BACK: begin
          if (held >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            entries[held] = v;
            held++;
          end
        end
        OP_PUSH_FRONT: begin
          if (held >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            open_at(0);
            entries[0] = v;
            held++;
          end
        end
        OP_POP_BACK: begin
          if (held == 0) r.status = ST_EMPTY;
          else held--;
        end
        OP_POP_FRONT: begin
          if (held == 0) r.status = ST_EMPTY;
          else begin
            close_at(0);
            held--;
          end
        end
        OP_INSERT: begin
          if (pos > held) r.status = ST_RANGE;
          else if (held >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            open_at(pos);
            entries[pos] = v;
            held++;
          end
        end
        OP_ERASE: begin
          if (held == 0) r.status = ST_EMPTY;
          else if (pos >= held) r.status = ST_RANGE;
          else begin
            close_at(pos);
            held--;
          end
        end
        OP_READ: begin
          if (held == 0) r.status = ST_EMPTY;
          else if (pos >= held) r.status = ST_RANGE;
          else r.data = entries[pos];
        end
        default: ;
      endcase
      r.count = COUNT_W'(held);
      pending_q.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_result(logic [STAT_W-1:0] status, logic [COUNT_W-1:0] count,
                               logic [DATA_W-1:0] data);
      list_result_t r;
      if (pending_q.size() == 0) begin
        $display("%0t: result word with none expected: status %0d count %0d data %h",
                 $time, status, count, data);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      if (status !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (count !== r.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, r.count, count);
        errors++;
      end
      if (data !== r.data) begin
        $display("%0t: read_data expected %h actual %h", $time, r.data, data);
        errors++;
      end
    endfunction
  endclass

endpackage

/* sim/tb_positional_list_store_top.sv */
// Testbench top for the positional list store: directed and random operation words.
`timescale 1ns / 100ps

module tb_positional_list_store_top;
  import pls_pkg::*;
  import pls_list_board_pkg::*;

  // Code 7 is not an operation; the block must answer it with no effect.
  localparam logic [OP_W-1:0]    OP_UNUSED   = 3'd7;
  localparam logic [POS_W-1:0]   POS_MAX     = '1;
  localparam logic [VALUE_W-1:0] VALUE_ONES  = '1;
  localparam int                 RAND_ITEMS  = 1725;
  // The longest gap or stall from pick_gap is far below this; anything near it is a hang.
  localparam int                 IDLE_LIMIT  = 5000;
  localparam int                 DRAIN_TICKS = 10;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_e;

  logic clk_i;
  logic rst_ni;

  pls_op_if  op_if ();
  pls_res_if res_if ();

  positional_list_store_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_if),
    .res_o  (res_if)
  );

  list_result_board sb = new();

  // Set for whole phases: drop all gaps and stalls on both sides.
  bit calm;
  int idle_ticks;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Weight the operation mix so that a grow phase runs into the full list
  // and a shrink phase drains it to empty.
  function automatic logic [OP_W-1:0] pick_op(phase_e ph);
    int c [7];
    int r;
    case (ph)
      PH_GROW:   c = '{25, 45, 53, 59, 77, 83, 99};
      PH_SHRINK: c = '{7, 13, 33, 53, 60, 80, 99};
      default:   c = '{14, 28, 42, 56, 70, 84, 99};
    endcase
    r = $urandom_range(0, 99);
    if (r < c[0]) return OP_PUSH_BACK;
    if (r < c[1]) return OP_PUSH_FRONT;
    if (r < c[2]) return OP_POP_BACK;
    if (r < c[3]) return OP_POP_FRONT;
    if (r < c[4]) return OP_INSERT;
    if (r < c[5]) return OP_ERASE;
    if (r < c[6]) return OP_READ;
    return OP_UNUSED;
  endfunction

  // Aim most positions inside the list, some on its edge, a few anywhere.
  function automatic logic [POS_W-1:0] pick_pos(int held);
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return POS_W'($urandom_range(0, held));
    if (r < 80) return POS_W'(held);
    if (r < 86) return POS_W'((held > 0) ? held - 1 : 0);
    if (r < 91) return POS_W'(LIST_DEPTH);
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return VALUE_ONES;
    return $urandom;
  endfunction

  // Present one word after a random gap and hold it until it is taken.
  // Called at a rising edge; valid gets exactly one assignment per edge.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      op_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_if.valid     <= 1'b1;
    op_if.operation <= op;
    op_if.position  <= pos;
    op_if.value     <= value;
    do @(posedge clk_i); while (!op_if.ready);
    sb.note_op(op, pos, value);
  endtask

  // Result side: take words, check them, stall at random.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        sb.check_result(res_if.status, res_if.entry_count, res_if.read_data);
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          res_if.ready <= 1'b0;
          stall_left--;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_ticks <= 0;
    end else if (idle_ticks >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_ticks <= idle_ticks + 1;
    end
  end

  initial begin : stimulus
    int     sent;
    int     phase_len;
    phase_e ph;
    logic [OP_W-1:0] op;

    calm            = 1'b0;
    rst_ni          <= 1'b0;
    op_if.valid     <= 1'b0;
    op_if.operation <= OP_READ;
    op_if.position  <= '0;
    op_if.value     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every removal and read is refused.
    send_op(OP_POP_BACK, '0, '0);
    send_op(OP_POP_FRONT, '0, '0);
    send_op(OP_ERASE, '0, '0);
    send_op(OP_READ, '0, '0);
    send_op(OP_READ, POS_MAX, '0);
    // Insert past the end, including the widest position.
    send_op(OP_INSERT, 7'd1, 32'h1111_1111);
    send_op(OP_INSERT, POS_MAX, VALUE_ONES);
    send_op(OP_UNUSED, POS_MAX, VALUE_ONES);
    // Build a short list through every way in.
    send_op(OP_INSERT, '0, '0);
    send_op(OP_PUSH_BACK, POS_MAX, VALUE_ONES);
    send_op(OP_PUSH_FRONT, '0, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 7'd3, 32'h5A5A_5A5A);
    send_op(OP_INSERT, 7'd1, 32'h1234_5678);
    for (int i = 0; i < 5; i++) send_op(OP_READ, POS_W'(i), VALUE_ONES);
    // Read and erase just past the end, then shrink from every side.
    send_op(OP_READ, 7'd5, '0);
    send_op(OP_ERASE, 7'd5, '0);
    send_op(OP_ERASE, 7'd2, '0);
    send_op(OP_POP_FRONT, '0, '0);
    send_op(OP_POP_BACK, '0, '0);
    send_op(OP_READ, '0, '0);
    send_op(OP_READ, 7'd1, '0);

    // Random phases; start with a grow phase so the full list is reached early.
    sent = 0;
    ph   = PH_GROW;
    while (sent < RAND_ITEMS) begin
      phase_len = $urandom_range(60, 150);
      calm      = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && sent < RAND_ITEMS; i++) begin
        op = pick_op(ph);
        send_op(op, pick_pos(sb.held_count()), pick_value());
        sent++;
      end
      ph = phase_e'($urandom_range(0, 2));
    end

    op_if.valid <= 1'b0;
    calm        = 1'b0;
    // Drain: wait for every predicted word, then wait out DRAIN_TICKS for strays.
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pls_pkg.sv
hdl/pls_if.sv
hdl/pls_cell.sv
hdl/pls_cell_row.sv
hdl/positional_list_store_top.sv
sim/pls_list_board_pkg.sv
sim/tb_positional_list_store_top.sv
